@@ sv/tlpw_pkg.sv @@
// tlpw_pkg: shared types and constants for the two-level page walk block
// no dependencies
`timescale 1ns / 1ps

package tlpw_pkg;

   localparam int EntriesPerFrame = 8;
   localparam int NumFrames       = 256;
   localparam int VirtPages       = 64;
   localparam int MaxProcs        = 16;

   localparam int IdxW   = $clog2(EntriesPerFrame);
   localparam int FrameW = $clog2(NumFrames);
   localparam int AddrW  = FrameW + IdxW;
   localparam int ProcW  = $clog2(MaxProcs);
   localparam int PageW  = $clog2(VirtPages);
   localparam int NextW  = 10;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_OOM    = 2'd1;
   localparam logic [1:0] ST_HALTED = 2'd2;
   localparam logic [1:0] ST_BADPID = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [FrameW-1:0] frame;
      logic [7:0]        count;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic upd_l1;
      logic upd_l2;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic early;
      logic fail;
   } sts_type;

endpackage

@@ sv/tlpw_ctrl.sv @@
// tlpw_ctrl: sequencer for store clearing and the two-level walk
// depends on tlpw_pkg
`timescale 1ns / 1ps

module tlpw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  tlpw_pkg::sts_type sts,
   output tlpw_pkg::cmd_type cmd
);
   import tlpw_pkg::*;

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_L1RD, S_L1UP, S_L2RD, S_L2UP, S_FIN, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.early ? S_FIN : S_L1RD;
            end
         end
         S_L1RD: state_in = S_L1UP;
         S_L1UP: begin
            cmd.upd_l1 = 1'b1;
            state_in   = sts.fail ? S_FIN : S_L2RD;
         end
         S_L2RD: state_in = S_L2UP;
         S_L2UP: begin
            cmd.upd_l2 = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLR;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

@@ sv/tlpw_dp.sv @@
// tlpw_dp: entry store, frame allocator, per-process counters and result registers
// depends on tlpw_pkg
`timescale 1ns / 1ps

module tlpw_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tlpw_pkg::ProcW-1:0]      req_proc_id,
   input  logic [tlpw_pkg::PageW-1:0]      req_virt_page,
   input  logic                            csr_wr_en,
   input  logic [4:0]                      csr_wr_data,
   input  tlpw_pkg::cmd_type               cmd,
   output tlpw_pkg::sts_type               sts,
   output logic [1:0]                      rsp_status,
   output logic [tlpw_pkg::FrameW-1:0]     rsp_l1_frame,
   output logic [tlpw_pkg::FrameW-1:0]     rsp_data_frame,
   output logic                            rsp_l1_fault,
   output logic                            rsp_l2_fault,
   output logic [7:0]                      rsp_page_ref_count,
   output logic [8:0]                      rsp_proc_fault_count,
   output logic [15:0]                     rsp_proc_ref_count,
   output logic [8:0]                      rsp_proc_alloc_count
);
   import tlpw_pkg::*;

   entry_type mem [2**AddrW];
   entry_type rdata_ff;

   logic [AddrW-1:0]  clr_ff, addr_ff, wr_addr;
   logic              wr_en;
   entry_type         wr_data;
   logic [4:0]        nproc_ff, active;
   logic [8:0]        handed_ff;
   logic              oom_ff;
   logic [ProcW-1:0]  proc_ff;
   logic [PageW-1:0]  page_ff;
   logic [1:0]        code_ff, code_in;
   logic [FrameW-1:0] l1f_ff, dataf_ff;
   logic              f1_ff, f2_ff;
   logic [7:0]        pcnt_ff;
   logic [8:0]        fault_ff [MaxProcs];
   logic [15:0]       ref_ff   [MaxProcs];
   logic [8:0]        alloc_ff [MaxProcs];

   logic [NextW-1:0]  next_frame;
   logic              hit, upd;
   logic [FrameW-1:0] new_frame;
   logic [7:0]        new_count;
   logic              bad_pid;

   assign active     = (nproc_ff > 5'(MaxProcs)) ? 5'(MaxProcs) : nproc_ff;
   assign bad_pid    = ({1'b0, req_proc_id} >= active);
   assign code_in    = oom_ff ? ST_HALTED : (bad_pid ? ST_BADPID : ST_OK);
   assign hit        = rdata_ff.valid;
   assign upd        = cmd.upd_l1 | cmd.upd_l2;
   assign next_frame = NextW'(active) + NextW'(handed_ff);
   assign new_frame  = hit ? rdata_ff.frame : next_frame[FrameW-1:0];
   assign new_count  = rdata_ff.count + 8'd1;

   assign sts.clear_last = (clr_ff == '1);
   assign sts.early      = (code_in != ST_OK);
   assign sts.fail       = !hit && (next_frame >= NextW'(NumFrames));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '{valid: 1'b1, frame: new_frame, count: new_count};
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (upd && !sts.fail) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         nproc_ff  <= 5'd1;
         handed_ff <= '0;
         oom_ff    <= 1'b0;
         for (int i = 0; i < MaxProcs; i++) begin
            fault_ff[i] <= '0;
            ref_ff[i]   <= '0;
            alloc_ff[i] <= 9'd1;
         end
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (csr_wr_en) nproc_ff <= csr_wr_data;
         if (upd) begin
            if (sts.fail) begin
               oom_ff <= 1'b1;
            end else begin
               if (!hit) begin
                  handed_ff         <= handed_ff + 9'd1;
                  fault_ff[proc_ff] <= fault_ff[proc_ff] + 9'd1;
                  alloc_ff[proc_ff] <= alloc_ff[proc_ff] + 9'd1;
               end
               if (cmd.upd_l2 && ref_ff[proc_ff] != 16'hFFFF)
                  ref_ff[proc_ff] <= ref_ff[proc_ff] + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         proc_ff  <= req_proc_id;
         page_ff  <= req_virt_page;
         code_ff  <= code_in;
         addr_ff  <= {FrameW'(req_proc_id), req_virt_page[2*IdxW-1:IdxW]};
         l1f_ff   <= '0;
         dataf_ff <= '0;
         f1_ff    <= 1'b0;
         f2_ff    <= 1'b0;
         pcnt_ff  <= '0;
      end
      if (upd && sts.fail) code_ff <= ST_OOM;
      if (cmd.upd_l1 && !sts.fail) begin
         l1f_ff  <= new_frame;
         f1_ff   <= !hit;
         addr_ff <= {new_frame, page_ff[IdxW-1:0]};
      end
      if (cmd.upd_l2 && !sts.fail) begin
         dataf_ff <= new_frame;
         f2_ff    <= !hit;
         pcnt_ff  <= new_count;
      end
      if (cmd.finish) begin
         rsp_status         <= code_ff;
         rsp_l1_frame       <= l1f_ff;
         rsp_data_frame     <= dataf_ff;
         rsp_l1_fault       <= f1_ff;
         rsp_l2_fault       <= f2_ff;
         rsp_page_ref_count <= pcnt_ff;
         if (code_ff == ST_HALTED || code_ff == ST_BADPID) begin
            rsp_proc_fault_count <= '0;
            rsp_proc_ref_count   <= '0;
            rsp_proc_alloc_count <= '0;
         end else begin
            rsp_proc_fault_count <= fault_ff[proc_ff];
            rsp_proc_ref_count   <= ref_ff[proc_ff];
            rsp_proc_alloc_count <= alloc_ff[proc_ff];
         end
      end
   end

endmodule

@@ sv/two_level_page_walk_demand_alloc.sv @@
// two_level_page_walk_demand_alloc: top level, controller plus datapath
// depends on tlpw_pkg, tlpw_ctrl, tlpw_dp
// a walk makes two dependent read-modify-write passes on the entry store; one that
//   finds level 1 out of frames stops after the first read; a rejected one skips both
// req_ready stays low from acceptance until the response is taken, so only one
//   transaction is in flight at a time
// reset: synchronous; a clearing pass zeroes all 2048 entries of the store before
//   req_ready rises; csr writes are taken during it
`timescale 1ns / 1ps

module two_level_page_walk_demand_alloc (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_proc_id,
   input  logic [5:0]  req_virt_page,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_l1_frame,
   output logic [7:0]  rsp_data_frame,
   output logic        rsp_l1_fault,
   output logic        rsp_l2_fault,
   output logic [7:0]  rsp_page_ref_count,
   output logic [8:0]  rsp_proc_fault_count,
   output logic [15:0] rsp_proc_ref_count,
   output logic [8:0]  rsp_proc_alloc_count,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   import tlpw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tlpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlpw_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_proc_id          (req_proc_id),
      .req_virt_page        (req_virt_page),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_status           (rsp_status),
      .rsp_l1_frame         (rsp_l1_frame),
      .rsp_data_frame       (rsp_data_frame),
      .rsp_l1_fault         (rsp_l1_fault),
      .rsp_l2_fault         (rsp_l2_fault),
      .rsp_page_ref_count   (rsp_page_ref_count),
      .rsp_proc_fault_count (rsp_proc_fault_count),
      .rsp_proc_ref_count   (rsp_proc_ref_count),
      .rsp_proc_alloc_count (rsp_proc_alloc_count)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request taken while a response is pending");

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a transaction");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_HALTED || rsp_status == ST_BADPID)) |->
      (rsp_l1_frame == 8'd0 && rsp_proc_alloc_count == 9'd0 && !rsp_l1_fault))
      else $error("rejected transaction carries nonzero fields");

endmodule
